@@ hdl/atic_pkg.sv @@
// Shared types and constants of the activation table interpolator.
package atic_pkg;

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;
   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

   // Request kinds
   typedef enum logic {
      REQ_TABLE_WRITE = 1'b0,
      REQ_EVALUATE    = 1'b1
   } req_kind_type;

   // Function select codes
   localparam logic FUNC_TANH     = 1'b0;
   localparam logic FUNC_LOGISTIC = 1'b1;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_FUNCTION_SELECT  = 2'd0;
   localparam logic [1:0] CSR_MULTIPLY_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_INPUT_SCALE      = 2'd2;
   localparam logic [1:0] CSR_TABLE_LAST_INDEX = 2'd3;

   // 1.0 in Q4.12
   localparam logic [13:0] ONE_Q12 = 14'd4096;

   typedef struct packed {
      logic        function_select;
      logic        multiply_enable;
      logic [15:0] input_scale;
      logic [9:0]  table_last_index;
   } cfg_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [9:0]         table_addr;
      logic [15:0]        table_word;
      logic               neg;
      logic [16:0]        mag;
      logic signed [15:0] mul_value;
      logic               is_last;
   } queue_entry_type;

   typedef struct packed {
      logic              head_valid;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage

@@ hdl/activation_table_interpolator_core.sv @@
// Top level: configuration registers, item queue and evaluation pipeline.
// Throughput: one item per cycle unless an untaken result stalls the pipeline; a table
// write takes one slot and yields no result. Each item passes the queue, then the pipeline.
// The scale multiplier, the two-port table read and the interpolation multiply are
// each one pipeline stage, so the rate is set by the single table read per item.
// Reset (synchronous) empties queue and pipeline and loads register defaults;
// the table holds nothing defined until written.
module activation_table_interpolator_core
   import atic_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [9:0]         req_table_addr,
   input  logic [15:0]        req_table_word,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_mul_value,
   input  logic               req_is_last_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_y_value,
   output logic               rsp_beyond_table,
   output logic               rsp_is_last_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic             function_select_ff;
   logic             multiply_enable_ff;
   logic [15:0]      input_scale_ff;
   logic [9:0]       table_last_index_ff;
   logic             csr_write;
   cfg_type          cfg;
   queue_entry_type  head;
   queue_status_type status;
   logic             pop;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         function_select_ff <= 1'b0;
         multiply_enable_ff <= 1'b0;
         input_scale_ff <= 16'd256;
         table_last_index_ff <= 10'd1023;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            CSR_FUNCTION_SELECT:  function_select_ff <= pwdata[0];
            CSR_MULTIPLY_ENABLE:  multiply_enable_ff <= pwdata[0];
            CSR_INPUT_SCALE:      input_scale_ff <= pwdata[15:0];
            CSR_TABLE_LAST_INDEX: table_last_index_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[3:2])
         CSR_FUNCTION_SELECT:  prdata = 32'(function_select_ff);
         CSR_MULTIPLY_ENABLE:  prdata = 32'(multiply_enable_ff);
         CSR_INPUT_SCALE:      prdata = 32'(input_scale_ff);
         CSR_TABLE_LAST_INDEX: prdata = 32'(table_last_index_ff);
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      cfg.function_select = function_select_ff;
      cfg.multiply_enable = multiply_enable_ff;
      cfg.input_scale = input_scale_ff;
      cfg.table_last_index = table_last_index_ff;
   end

   atic_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_table_addr (req_table_addr),
      .req_table_word (req_table_word),
      .req_x_value    (req_x_value),
      .req_mul_value  (req_mul_value),
      .req_is_last_in (req_is_last_in),
      .pop            (pop),
      .head           (head),
      .status         (status)
   );

   atic_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head             (head),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_y_value      (rsp_y_value),
      .rsp_beyond_table (rsp_beyond_table),
      .rsp_is_last_out  (rsp_is_last_out)
   );

   // Saturated tanh without multiply is exactly plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beyond_table && !multiply_enable_ff &&
      (function_select_ff == FUNC_TANH) |->
      (rsp_y_value == 16'sd4096 || rsp_y_value == -16'sd4096))
      else $error("saturated tanh result is not +/-1");

   // Queue never overfills and never pops when empty
   assert property (@(posedge clock) disable iff (reset)
      (status.count <= QUEUE_FULL) && (!pop || status.head_valid))
      else $error("item queue over or underflow");

   // Reset leaves no result pending
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ hdl/atic_front.sv @@
// Front end: accepts items, folds the sign and queues them in order.
module atic_front
   import atic_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [9:0]         req_table_addr,
   input  logic [15:0]        req_table_word,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_mul_value,
   input  logic               req_is_last_in,
   input  logic               pop,
   output queue_entry_type    head,
   output queue_status_type   status
);

   queue_entry_type         queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   queue_entry_type         entry;
   logic signed [16:0]      x_ext;
   logic                    push;

   // Classify and fold the sign of the incoming item
   always_comb begin
      x_ext = {req_x_value[15], req_x_value};
      entry.kind = req_kind_type'(req_type);
      entry.table_addr = req_table_addr;
      entry.table_word = req_table_word;
      entry.neg = req_x_value[15];
      entry.mag = req_x_value[15] ? 17'(-x_ext) : 17'(x_ext);
      entry.mul_value = req_mul_value;
      entry.is_last = req_is_last_in;
   end

   assign req_ready = (count_ff != QUEUE_FULL);
   assign push = req_valid && req_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head = queue_ff[rd_ptr_ff];
   assign status.head_valid = (count_ff != '0);
   assign status.count = count_ff;

endmodule

@@ hdl/atic_back.sv @@
// Back end: table memory, scale, interpolation, sign and multiply pipeline.
module atic_back
   import atic_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
)
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  queue_entry_type    head,
   input  queue_status_type   status,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_y_value,
   output logic               rsp_beyond_table,
   output logic               rsp_is_last_out
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
   localparam logic [31:0] LAST_ENTRY = 32'(TABLE_DEPTH - 1);

   logic [15:0] table_mem [TABLE_DEPTH];

   logic advance;

   // Stage 1: scaled magnitude
   logic               s1_valid_ff;
   logic [32:0]        s1_scaled_ff;
   logic               s1_neg_ff, s1_last_ff;
   logic signed [15:0] s1_mul_ff;

   // Stage 2: table entries and fraction
   logic               s2_valid_ff;
   logic [15:0]        s2_t0_ff, s2_t1_ff;
   logic [19:0]        s2_frac_ff;
   logic               s2_beyond_ff, s2_neg_ff, s2_last_ff;
   logic signed [15:0] s2_mul_ff;

   // Stage 3: slope times fraction
   logic               s3_valid_ff;
   logic signed [37:0] s3_prod_ff, s3_prod_in;
   logic [15:0]        s3_t0_ff;
   logic               s3_beyond_ff, s3_neg_ff, s3_last_ff;
   logic signed [15:0] s3_mul_ff;

   // Stage 4: signed activation
   logic               s4_valid_ff;
   logic signed [15:0] s4_y_ff, s4_y_in;
   logic               s4_beyond_ff, s4_last_ff;
   logic signed [15:0] s4_mul_ff;

   // Stage 5: product with multiplier
   logic               s5_valid_ff;
   logic signed [31:0] s5_p_ff, s5_p_in;
   logic               s5_beyond_ff, s5_last_ff;

   // Output register
   logic               out_valid_ff;
   logic signed [15:0] out_y_ff, out_y_in;
   logic               out_beyond_ff, out_last_ff;

   logic [31:0]        addr_wide;
   logic               wr_hit;
   logic [31:0]        limit;
   logic [12:0]        idx;
   logic [31:0]        idx_wide, idx_next;
   logic [AW-1:0]      rd_addr0, rd_addr1;
   logic               beyond;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop = advance && status.head_valid;

   // Table write decode
   always_comb begin
      addr_wide = 32'(head.table_addr);
      wr_hit = pop && (head.kind == REQ_TABLE_WRITE) && (addr_wide < DEPTH_W);
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         table_mem[addr_wide[AW-1:0]] <= head.table_word;
      end
   end

   // Index, saturation test and read addresses
   always_comb begin
      limit = (32'(cfg.table_last_index) > LAST_ENTRY) ? LAST_ENTRY :
              32'(cfg.table_last_index);
      idx = s1_scaled_ff[32:20];
      idx_wide = 32'(idx);
      idx_next = idx_wide + 32'd1;
      rd_addr0 = idx_wide[AW-1:0];
      rd_addr1 = idx_next[AW-1:0];
      beyond = (idx_wide >= limit);
   end

   // Read both neighbors
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_t0_ff <= table_mem[rd_addr0];
         s2_t1_ff <= table_mem[rd_addr1];
      end
   end

   // Slope times fraction
   always_comb begin
      logic signed [16:0] diff;
      logic signed [20:0] frac_s;
      diff = $signed({1'b0, s2_t1_ff}) - $signed({1'b0, s2_t0_ff});
      frac_s = $signed({1'b0, s2_frac_ff});
      s3_prod_in = diff * frac_s;
   end

   // Round to Q4.12 and restore the sign
   always_comb begin
      logic signed [37:0] acc;
      logic [13:0]        m;
      logic [13:0]        mm;
      logic signed [15:0] mm_s;
      acc = $signed({2'b00, s3_t0_ff, 20'd0}) + s3_prod_ff + 38'sd4194304;
      m = acc[36:23];
      mm = s3_beyond_ff ? ONE_Q12 : m;
      mm_s = $signed({2'b00, mm});
      if (cfg.function_select == FUNC_LOGISTIC) begin
         s4_y_in = s3_neg_ff ? $signed({2'b00, ONE_Q12}) - mm_s : mm_s;
      end else begin
         s4_y_in = s3_neg_ff ? -mm_s : mm_s;
      end
   end

   // Multiply; unity multiplier when disabled
   always_comb begin
      logic signed [15:0] op;
      op = cfg.multiply_enable ? s4_mul_ff : $signed({2'b00, ONE_Q12});
      s5_p_in = s4_y_ff * op;
   end

   // Round half up and saturate
   always_comb begin
      logic signed [32:0] pr;
      logic signed [20:0] q;
      pr = $signed({s5_p_ff[31], s5_p_ff}) + 33'sd2048;
      q = 21'(pr >>> 12);
      if (q > 21'sd32767) begin
         out_y_in = 16'sd32767;
      end else if (q < -21'sd32768) begin
         out_y_in = -16'sd32768;
      end else begin
         out_y_in = q[15:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop && (head.kind == REQ_EVALUATE);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         out_valid_ff <= s5_valid_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_scaled_ff <= 33'(head.mag) * 33'(cfg.input_scale);
         s1_neg_ff <= head.neg;
         s1_mul_ff <= head.mul_value;
         s1_last_ff <= head.is_last;

         s2_frac_ff <= s1_scaled_ff[19:0];
         s2_beyond_ff <= beyond;
         s2_neg_ff <= s1_neg_ff;
         s2_mul_ff <= s1_mul_ff;
         s2_last_ff <= s1_last_ff;

         s3_prod_ff <= s3_prod_in;
         s3_t0_ff <= s2_t0_ff;
         s3_beyond_ff <= s2_beyond_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_mul_ff <= s2_mul_ff;
         s3_last_ff <= s2_last_ff;

         s4_y_ff <= s4_y_in;
         s4_beyond_ff <= s3_beyond_ff;
         s4_mul_ff <= s3_mul_ff;
         s4_last_ff <= s3_last_ff;

         s5_p_ff <= s5_p_in;
         s5_beyond_ff <= s4_beyond_ff;
         s5_last_ff <= s4_last_ff;

         out_y_ff <= out_y_in;
         out_beyond_ff <= s5_beyond_ff;
         out_last_ff <= s5_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_y_value = out_y_ff;
   assign rsp_beyond_table = out_beyond_ff;
   assign rsp_is_last_out = out_last_ff;

endmodule
